// ===== rtl/lme_pkg.sv =====
`timescale 1ns / 1ps

package lme_pkg;

  localparam int COUNT_BITS = 24;
  localparam int LIMIT_W    = 24;
  localparam int BPC_W      = 3;
  localparam int CFG_W      = (LIMIT_W > BPC_W) ? LIMIT_W : BPC_W;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic             CFG_BPC   = 1'b0;
  localparam logic             CFG_LIMIT = 1'b1;

  localparam logic [BPC_W-1:0]   BPC_RESET   = 3'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  localparam logic [BPC_W-1:0] BPC_ONE  = 3'd1;
  localparam logic [BPC_W-1:0] BPC_TWO  = 3'd2;
  localparam logic [BPC_W-1:0] BPC_FOUR = 3'd4;

  localparam logic [7:0] CHAR_END   = 8'd127;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_PAREN = 8'h29;

  typedef enum logic [3:0] {
    PH_MSG   = 4'b0001,
    PH_COLON = 4'b0010,
    PH_PAREN = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] component_in;
    logic [7:0] next_char;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] component_out;
    logic       char_taken;
    logic       finished;
  } out_beat_t;

endpackage

// ===== rtl/lsb_message_embedder_top.sv =====
`timescale 1ns / 1ps

// Embeds a message, a few bits at a time, into the low bits of a stream of
// color components. Each input beat carries one component and the message
// byte on offer; each output beat carries the modified component, a flag
// that the offered byte was consumed, and a flag that the terminator is done.
// The configuration port takes bits per component (index 0) and the
// component limit (index 1); write it only while the block is idle.
// Results are registered in the output buffer; one beat is taken every
// cycle while the receiver keeps up. The per-beat work is a
// single pass of logic between the message state and the output register.
// A two-entry output buffer lets the block take one more beat while a result
// waits; when the receiver stalls longer, in_ready drops until a beat leaves.
// Reset clears the message state, returns the registers to two bits per
// component and the largest limit, and empties the output buffer.

module lsb_message_embedder_top
  import lme_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic      accept;
  out_beat_t res_beat;

  assign accept = in_valid && in_ready;

  lme_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .in_beat  (in_data),
    .res_beat (res_beat)
  );

  lme_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_beat (res_beat),
    .push_ready(in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_data)
  );

endmodule

// ===== rtl/lme_core.sv =====
`timescale 1ns / 1ps

module lme_core
  import lme_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             accept,
  input  in_beat_t         in_beat,
  output out_beat_t        res_beat
);

  logic [BPC_W-1:0]      bpc_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic [7:0]            char_r, char_nxt;
  logic [2:0]            cc_r, cc_nxt;
  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] used_r, used_nxt;

  logic       active;
  logic [2:0] chunks_m1;
  logic [2:0] cc_eff;
  logic [7:0] mask;
  logic [2:0] sh;
  logic [7:0] cur;
  logic       taken;
  logic [7:0] comp_res;

  always_comb begin
    active    = 1'b1;
    chunks_m1 = 3'd7;
    mask      = 8'h01;
    case (bpc_r)
      BPC_ONE: begin
        chunks_m1 = 3'd7;
        mask      = 8'h01;
      end
      BPC_TWO: begin
        chunks_m1 = 3'd3;
        mask      = 8'h03;
      end
      BPC_FOUR: begin
        chunks_m1 = 3'd1;
        mask      = 8'h0F;
      end
      default: begin
        active = 1'b0;
      end
    endcase
    if (phase_r == PH_DONE) begin
      active = 1'b0;
    end

    cc_eff = (cc_r > chunks_m1) ? 3'd0 : cc_r;

    char_nxt  = char_r;
    cc_nxt    = cc_r;
    phase_nxt = phase_r;
    used_nxt  = used_r;
    taken     = 1'b0;
    cur       = char_r;
    comp_res  = in_beat.component_in;
    sh        = 3'd0;

    if (active) begin
      if (cc_eff == 3'd0 && phase_r == PH_MSG) begin
        if (in_beat.next_char < CHAR_END &&
            CMP_W'(used_r) < CMP_W'(limit_r)) begin
          cur   = in_beat.next_char;
          taken = 1'b1;
        end else begin
          cur       = CHAR_COLON;
          phase_nxt = PH_COLON;
        end
      end

      case (bpc_r)
        BPC_ONE:  sh = 3'd7 - cc_eff;
        BPC_TWO:  sh = 3'd6 - {cc_eff[1:0], 1'b0};
        BPC_FOUR: sh = cc_eff[0] ? 3'd0 : 3'd4;
        default:  sh = 3'd0;
      endcase
      comp_res = (in_beat.component_in & ~mask) | ((cur >> sh) & mask);

      if (used_r != COUNT_MAX) begin
        used_nxt = used_r + COUNT_BITS'(1);
      end

      char_nxt = cur;
      if (cc_eff == chunks_m1) begin
        cc_nxt = 3'd0;
        if (phase_nxt == PH_COLON) begin
          phase_nxt = PH_PAREN;
          char_nxt  = CHAR_PAREN;
        end else if (phase_nxt == PH_PAREN) begin
          phase_nxt = PH_DONE;
        end
      end else begin
        cc_nxt = cc_eff + 3'd1;
      end
    end
  end

  assign res_beat.component_out = comp_res;
  assign res_beat.char_taken    = taken;
  assign res_beat.finished      = (phase_nxt == PH_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r   <= BPC_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BPC:   bpc_r   <= cfg_wdata[BPC_W-1:0];
        CFG_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default:   bpc_r   <= bpc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r  <= 8'd0;
      cc_r    <= 3'd0;
      phase_r <= PH_MSG;
      used_r  <= '0;
    end else if (accept) begin
      char_r  <= char_nxt;
      cc_r    <= cc_nxt;
      phase_r <= phase_nxt;
      used_r  <= used_nxt;
    end
  end

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("terminator phase left the done state");

  a_taken_only_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_beat.char_taken |-> phase_r == PH_MSG && cc_eff == 3'd0)
    else $error("character taken away from a message boundary");

endmodule

// ===== rtl/lme_out_buf.sv =====
`timescale 1ns / 1ps

module lme_out_buf
  import lme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_beat_t push_beat,
  output logic      push_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_beat_t main_r, main_nxt;
  out_beat_t skid_r, skid_nxt;
  logic      pop;

  assign pop        = main_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_beat   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_beat;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_beat;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held without a head entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("beat pushed into a full buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> main_valid_r && main_r == $past(skid_r))
    else $error("skid entry not promoted after a pop");

endmodule
